// ===== src/idalloc_pkg.sv =====
// Shared widths, reset values and status codes of the index/ID allocator.
package idalloc_pkg;

  // Width of one ID and of the counters that can reach the full 8-bit ID space
  localparam int unsigned IdW      = 8;
  localparam int unsigned CountW   = 9;
  localparam int unsigned IdSpace  = 256;

  // Reset value of the pool size register and default queue depth
  localparam logic [CountW-1:0] IndexCountReset = CountW'(256);
  localparam int unsigned       MaxIdsDefault   = 256;

  // Result status codes
  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusError = 2'd2
  } status_e;

endpackage

// ===== src/index_id_allocator_core.sv =====
// Free-list ID allocator: release queue in a synchronous memory plus a bump counter.
//
//  channel   | direction | tdata / data            | tuser / side
//  ----------+-----------+-------------------------+------------------------
//  s_axis    | in        | [7:0] release_index     | [0] func (0 alloc, 1 release)
//  m_axis    | out       | [7:0] granted_id,       | [1:0] status
//            |           | [16:8] in_use_count     |
//  cfg       | in        | [8:0] pool_ids          | -
//
// A request passes through an idle and an execute state: the queue memory is
// read at the head pointer on the accepting edge, and the execute state does the
// read-modify-write of the queue and counters and loads the result register. A
// stalled result holds the request in its execute state until m_axis_tready. Reset
// clears all pointers and counters; queue memory contents are not cleared and need no clearing pass.

module index_id_allocator_core #(
  parameter int unsigned MAX_IDS = idalloc_pkg::MaxIdsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] release_index
  input  logic        s_axis_tuser,   // [0] func
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] granted_id, [16:8] in_use_count, pad
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  // pool size register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i      // [8:0] pool_ids
);

  localparam int unsigned IdW    = idalloc_pkg::IdW;
  localparam int unsigned CountW = idalloc_pkg::CountW;
  localparam int unsigned PtrW   = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int unsigned FillW  = $clog2(MAX_IDS + 1);
  localparam int unsigned CapVal = (MAX_IDS < idalloc_pkg::IdSpace) ? MAX_IDS
                                                                    : idalloc_pkg::IdSpace;
  localparam logic [CountW-1:0] PoolCap  = CountW'(CapVal);
  localparam logic [PtrW-1:0]   PtrLast  = PtrW'(MAX_IDS - 1);
  localparam logic [FillW-1:0]  FillFull = FillW'(MAX_IDS);

  typedef enum logic {
    StIdle,
    StExec
  } state_e;

  state_e                state_q, state_d;
  logic [CountW-1:0]     pool_ids_q;
  logic [PtrW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [FillW-1:0]      fill_q, fill_d;
  logic [CountW-1:0]     fresh_q, fresh_d;
  logic [CountW-1:0]     used_q, used_d;
  logic                  func_q;
  logic [IdW-1:0]        rel_q;
  logic [IdW-1:0]        rd_data_q;
  logic                  out_valid_q;
  logic [1:0]            status_q, status_d;
  logic [IdW-1:0]        alloc_q, alloc_d;
  logic [CountW-1:0]     count_q;
  logic [CountW-1:0]     pool_size;
  logic                  in_xfer, exec_go, out_xfer, mem_we;

  // Release queue storage
  logic [IdW-1:0] queue_mem [MAX_IDS];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = out_valid_q && m_axis_tready;
  assign exec_go       = (state_q == StExec) && (!out_valid_q || m_axis_tready);

  assign pool_size = (pool_ids_q > PoolCap) ? PoolCap : pool_ids_q;

  // Queue memory: one write port at the tail, registered read at the head
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      queue_mem[tail_q] <= rel_q;
    end
    rd_data_q <= queue_mem[head_q];
  end

  // Request execution: allocate from queue, then fresh counter; release to tail
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    fresh_d  = fresh_q;
    used_d   = used_q;
    status_d = idalloc_pkg::StatusOk;
    alloc_d  = '0;
    mem_we   = 1'b0;
    if (!func_q) begin
      priority if (fill_q != '0) begin
        alloc_d = rd_data_q;
        head_d  = (head_q == PtrLast) ? '0 : head_q + PtrW'(1);
        fill_d  = fill_q - FillW'(1);
        used_d  = used_q + CountW'(1);
      end else if (fresh_q < pool_size) begin
        alloc_d = fresh_q[IdW-1:0];
        fresh_d = fresh_q + CountW'(1);
        used_d  = used_q + CountW'(1);
      end else begin
        status_d = idalloc_pkg::StatusEmpty;
      end
    end else begin
      if ({1'b0, rel_q} >= pool_size || used_q == '0 || fill_q >= FillFull) begin
        status_d = idalloc_pkg::StatusError;
      end else begin
        mem_we = exec_go;
        tail_d = (tail_q == PtrLast) ? '0 : tail_q + PtrW'(1);
        fill_d = fill_q + FillW'(1);
        used_d = used_q - CountW'(1);
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_xfer) state_d = StExec;
      StExec: if (exec_go) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // State, counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      pool_ids_q    <= idalloc_pkg::IndexCountReset;
      head_q        <= '0;
      tail_q        <= '0;
      fill_q        <= '0;
      fresh_q       <= '0;
      used_q        <= '0;
      out_valid_q   <= 1'b0;
      status_q      <= idalloc_pkg::StatusOk;
      alloc_q       <= '0;
      count_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        pool_ids_q <= cfg_data_i;
      end
      if (exec_go) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        fill_q      <= fill_d;
        fresh_q     <= fresh_d;
        used_q      <= used_d;
        out_valid_q <= 1'b1;
        status_q    <= status_d;
        alloc_q     <= alloc_d;
        count_q     <= used_d;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q <= s_axis_tuser;
      rel_q  <= s_axis_tdata;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {7'd0, count_q, alloc_q};

  // Every ID handed out is either in use or waiting in the queue
  a_id_conservation: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(used_q) + 32'(fill_q)) == 32'(fresh_q))
    else $error("in-use count plus queue fill differs from fresh IDs issued");

  // Fresh counter never passes the addressable pool and queue never overfills
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= PoolCap && fill_q <= FillFull)
    else $error("fresh counter or queue fill out of range");

  // An accepted request enters the execute state next cycle, and results are never overwritten
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == StExec))
    else $error("accepted request did not enter execute");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_go && out_valid_q) |-> m_axis_tready)
    else $error("result register loaded while holding an untaken result");

endmodule
